// File: rtl/adrc_pkg.sv
// Package with shared types, constants and tables for the audio compressor.
package adrc_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int COEF_WIDTH_DEF   = 16;

    localparam int DB_W = 17;

    localparam logic signed [DB_W-1:0] DB_FLOOR  = -17'sd46080;
    localparam logic signed [DB_W-1:0] ENV_RESET = -17'sd36864;
    localparam logic [18:0] DB_PER_LOG2_Q16 = 19'd394566;
    localparam logic [13:0] LOG2_PER_DB_Q16 = 14'd10885;
    localparam logic [12:0] MAKEUP_MAX = 13'd6144;
    localparam logic [16:0] INV_ONE = 17'd65536;

    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_BYPASS    = 3'd0;
    localparam logic [2:0] REG_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_INV_RATIO = 3'd2;
    localparam logic [2:0] REG_ATTACK    = 3'd3;
    localparam logic [2:0] REG_RELEASE   = 3'd4;
    localparam logic [2:0] REG_MAKEUP    = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOG,
        ST_DB,
        ST_ENV,
        ST_GAIN,
        ST_EXP,
        ST_INTERP,
        ST_MUL,
        ST_DONE
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;
        logic do_log;
        logic do_db;
        logic do_env;
        logic do_gain;
        logic do_exp;
        logic do_interp;
        logic do_mul;
    } cmd_t;

    typedef struct packed {
        logic bypass;
    } status_t;

    function automatic logic [16:0] log2_lut(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0:  v = 17'd0;
            5'd1:  v = 17'd5732;
            5'd2:  v = 17'd11136;
            5'd3:  v = 17'd16248;
            5'd4:  v = 17'd21098;
            5'd5:  v = 17'd25711;
            5'd6:  v = 17'd30109;
            5'd7:  v = 17'd34312;
            5'd8:  v = 17'd38336;
            5'd9:  v = 17'd42196;
            5'd10: v = 17'd45903;
            5'd11: v = 17'd49471;
            5'd12: v = 17'd52910;
            5'd13: v = 17'd56228;
            5'd14: v = 17'd59433;
            5'd15: v = 17'd62534;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    function automatic logic [17:0] exp2_lut(input logic [4:0] i);
        logic [17:0] v;
        case (i)
            5'd0:  v = 18'd65536;
            5'd1:  v = 18'd68438;
            5'd2:  v = 18'd71468;
            5'd3:  v = 18'd74632;
            5'd4:  v = 18'd77936;
            5'd5:  v = 18'd81386;
            5'd6:  v = 18'd84990;
            5'd7:  v = 18'd88752;
            5'd8:  v = 18'd92682;
            5'd9:  v = 18'd96785;
            5'd10: v = 18'd101070;
            5'd11: v = 18'd105545;
            5'd12: v = 18'd110218;
            5'd13: v = 18'd115098;
            5'd14: v = 18'd120194;
            5'd15: v = 18'd125515;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/adrc_ctrl.sv
// Sequencer that steps one sample through the compressor datapath.
module adrc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              out_free,
    input  adrc_pkg::status_t status,
    output adrc_pkg::cmd_t    cmd,
    output logic              s_ready,
    output logic              out_load
);
    import adrc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_ready  = 1'b1;
                cmd.load = in_fire;
                if (in_fire)
                begin
                    state_next = ST_LOG;
                end
            end
            ST_LOG:
            begin
                if (status.bypass)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.do_log = 1'b1;
                    state_next = ST_DB;
                end
            end
            ST_DB:
            begin
                cmd.do_db  = 1'b1;
                state_next = ST_ENV;
            end
            ST_ENV:
            begin
                cmd.do_env = 1'b1;
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                cmd.do_gain = 1'b1;
                state_next  = ST_EXP;
            end
            ST_EXP:
            begin
                cmd.do_exp = 1'b1;
                state_next = ST_INTERP;
            end
            ST_INTERP:
            begin
                cmd.do_interp = 1'b1;
                state_next    = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.do_mul = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/adrc_dp.sv
// Datapath: level detector, envelope, gain computer and gain multiplier.
module adrc_dp
#(
    parameter int SAMPLE_WIDTH = adrc_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = adrc_pkg::COEF_WIDTH_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  adrc_pkg::cmd_t                        cmd,
    input  logic signed [SAMPLE_WIDTH-1:0]        sample_in,
    input  logic                                  bypass_enable,
    input  logic signed [14:0]                    threshold_db,
    input  logic [16:0]                           inverse_ratio,
    input  logic [COEF_WIDTH-1:0]                 attack_coeff,
    input  logic [COEF_WIDTH-1:0]                 release_coeff,
    input  logic [12:0]                           makeup_db,
    output adrc_pkg::status_t                     status,
    output logic signed [SAMPLE_WIDTH-1:0]        sample_out,
    output logic signed [adrc_pkg::DB_W-1:0]      gain_db
);
    import adrc_pkg::*;

    localparam int SW   = SAMPLE_WIDTH;
    localparam int EW   = $clog2(SW);
    localparam int NEGW = EW + 17;
    localparam int PW   = SW + 18;
    localparam int SHW  = $clog2(PW + 2);

    logic signed [SW-1:0] x_reg;
    logic [SW-1:0]        mag_reg;
    logic                 byp_reg;
    logic                 zero_reg;
    logic [NEGW-1:0]      neg_reg;
    logic signed [DB_W-1:0] level_reg;
    logic signed [DB_W-1:0] env_reg;
    logic signed [DB_W-1:0] gain_reg;
    logic signed [23:0]   e2_reg;
    logic [17:0]          m_reg;
    logic [PW-1:0]        p_reg;

    assign status.bypass = byp_reg;
    assign gain_db       = byp_reg ? '0 : gain_reg;

    // Leading one search and log2 table interpolation.
    logic [EW-1:0] e_pos;
    logic [31:0]   norm;
    logic [3:0]    lidx;
    logic [15:0]   lrem;
    logic [16:0]   lt0;
    logic [16:0]   lt1;
    logic [33:0]   lprod;
    logic [16:0]   fr;
    logic signed [NEGW:0] neg_s;
    always_comb
    begin
        e_pos = '0;
        for (int i = 0; i < SW; i++)
        begin
            if (mag_reg[i])
            begin
                e_pos = EW'(i);
            end
        end
        norm  = 32'({mag_reg, {(32 - SW){1'b0}}} << (SW - 1 - int'(e_pos)));
        lidx  = norm[30:27];
        lrem  = norm[26:11];
        lt0   = log2_lut({1'b0, lidx});
        lt1   = log2_lut({1'b0, lidx} + 5'd1);
        lprod = (lt1 - lt0) * lrem;
        fr    = lt0 + 17'(lprod >> 16);
        neg_s = $signed({1'b0, NEGW'(SW - 1 - int'(e_pos)) << 16}) - $signed({1'b0, NEGW'(fr)});
    end

    // dB conversion.
    logic [NEGW+19:0] dbp;
    assign dbp = neg_reg * DB_PER_LOG2_Q16 + (NEGW+20)'(1 << 23);

    // Envelope smoothing.
    logic [COEF_WIDTH-1:0]  c;
    logic [COEF_WIDTH:0]    cinv;
    logic signed [DB_W+COEF_WIDTH+2:0] s_sum;
    logic signed [DB_W-1:0] env_new;
    always_comb
    begin
        c     = (level_reg > env_reg) ? attack_coeff : release_coeff;
        cinv  = (COEF_WIDTH+1)'(1 << COEF_WIDTH) - {1'b0, c};
        s_sum = $signed({1'b0, c}) * env_reg + $signed({1'b0, cinv}) * level_reg
                + $signed((DB_W+COEF_WIDTH+3)'(1 << (COEF_WIDTH - 1)));
        env_new = DB_W'(s_sum >>> COEF_WIDTH);
    end

    // Gain computer.
    logic [16:0] inv;
    logic signed [DB_W+1:0] over;
    logic [DB_W+17:0] red;
    logic signed [DB_W+1:0] g;
    logic [12:0] mk;
    always_comb
    begin
        inv  = (inverse_ratio > INV_ONE) ? INV_ONE : inverse_ratio;
        over = $signed({env_reg[DB_W-1], env_reg}) - $signed(threshold_db);
        red  = (DB_W+18)'($unsigned(over)) * (INV_ONE - inv) + (DB_W+18)'(32768);
        g    = (over > 0) ? -$signed((DB_W+2)'(red >> 16)) : '0;
        mk   = (makeup_db > MAKEUP_MAX) ? MAKEUP_MAX : makeup_db;
    end

    // Exponent in Q16.
    logic signed [31:0] t;
    logic [31:0] tabs;
    logic [23:0] tr;
    always_comb
    begin
        t    = gain_reg * $signed({1'b0, LOG2_PER_DB_Q16});
        tabs = t[31] ? 32'(-t) : 32'(t);
        tr   = 24'((tabs + 32'd128) >> 8);
    end

    // exp2 table interpolation.
    logic signed [7:0] n;
    logic [15:0] f;
    logic [17:0] et0;
    logic [17:0] et1;
    logic [29:0] eprod;
    always_comb
    begin
        n     = 8'(e2_reg >>> 16);
        f     = e2_reg[15:0];
        et0   = exp2_lut({1'b0, f[15:12]});
        et1   = exp2_lut({1'b0, f[15:12]} + 5'd1);
        eprod = (et1 - et0) * f[11:0];
    end

    // Final scaling, rounding and saturation.
    logic signed [8:0] sh;
    logic [SHW-1:0] shu;
    logic [PW:0] r;
    logic [SW-1:0] lim;
    logic [PW:0] rs;
    always_comb
    begin
        sh  = 9'sd16 - 9'(n);
        shu = (sh < 1) ? SHW'(1) : ((sh > PW) ? SHW'(PW + 1) : SHW'(sh));
        r   = ({1'b0, p_reg} + ((PW+1)'(1) << (shu - 1))) >> shu;
        lim = x_reg[SW-1] ? (SW'(1) << (SW - 1)) : ((SW'(1) << (SW - 1)) - SW'(1));
        rs  = (r > (PW+1)'(lim)) ? (PW+1)'(lim) : r;
    end

    // The scaled sample is ready while the sequencer waits to hand it over.
    assign sample_out = byp_reg ? x_reg : (x_reg[SW-1] ? SW'(-rs) : SW'(rs));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            env_reg <= ENV_RESET;
            byp_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                byp_reg <= bypass_enable;
            end
            if (cmd.do_env)
            begin
                env_reg <= env_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= sample_in;
            mag_reg  <= sample_in[SW-1] ? SW'(-sample_in) : SW'(sample_in);
            zero_reg <= (sample_in == '0);
            gain_reg <= '0;
        end
        if (cmd.do_log)
        begin
            neg_reg <= neg_s[NEGW] ? '0 : neg_s[NEGW-1:0];
        end
        if (cmd.do_db)
        begin
            level_reg <= zero_reg ? DB_FLOOR : -$signed(DB_W'(dbp >> 24));
        end
        if (cmd.do_gain)
        begin
            gain_reg <= DB_W'(g + $signed({1'b0, mk}));
        end
        if (cmd.do_exp)
        begin
            e2_reg <= t[31] ? -$signed(tr) : $signed(tr);
        end
        if (cmd.do_interp)
        begin
            m_reg <= et0 + 18'(eprod >> 12);
        end
        if (cmd.do_mul)
        begin
            p_reg <= mag_reg * m_reg;
        end
    end

endmodule

// File: rtl/audio_dynamic_range_compressor.sv
// Top level of the feedforward hard-knee audio compressor.
// The sequencer takes a new sample only once the previous one has been loaded into
// the output register; for each sample it steps the single shared datapath through
// log, dB, envelope, gain, exp, interpolation and multiply, all skipped in bypass.
// Reset (rst_n, asynchronous, active low) clears the sequencer, the output
// valid, the registers to their defaults and the envelope to -144 dB.
module audio_dynamic_range_compressor
#(
    parameter int SAMPLE_WIDTH = adrc_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = adrc_pkg::COEF_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // s_axis_tdata: sample_in (bits SAMPLE_WIDTH-1:0), zero padded.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // m_axis_tdata: sample_out, then gain_db (17 bits), zero padded.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [((SAMPLE_WIDTH+17+7)/8)*8-1:0] m_axis_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [adrc_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import adrc_pkg::*;

    localparam int OW = ((SAMPLE_WIDTH + 17 + 7) / 8) * 8;

    logic                  bypass_reg;
    logic signed [14:0]    threshold_reg;
    logic [16:0]           inv_ratio_reg;
    logic [COEF_WIDTH-1:0] attack_reg;
    logic [COEF_WIDTH-1:0] release_reg;
    logic [12:0]           makeup_reg;

    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg    <= 1'b0;
            threshold_reg <= '0;
            inv_ratio_reg <= INV_ONE;
            attack_reg    <= '0;
            release_reg   <= '0;
            makeup_reg    <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_BYPASS:    bypass_reg    <= pwdata[0];
                REG_THRESHOLD: threshold_reg <= pwdata[14:0];
                REG_INV_RATIO: inv_ratio_reg <= pwdata[16:0];
                REG_ATTACK:    attack_reg    <= pwdata[COEF_WIDTH-1:0];
                REG_RELEASE:   release_reg   <= pwdata[COEF_WIDTH-1:0];
                REG_MAKEUP:    makeup_reg    <= pwdata[12:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            REG_BYPASS:    prdata = {31'd0, bypass_reg};
            REG_THRESHOLD: prdata = 32'($unsigned(threshold_reg));
            REG_INV_RATIO: prdata = 32'(inv_ratio_reg);
            REG_ATTACK:    prdata = 32'(attack_reg);
            REG_RELEASE:   prdata = 32'(release_reg);
            REG_MAKEUP:    prdata = 32'(makeup_reg);
            default:       prdata = '0;
        endcase
    end

    cmd_t    cmd;
    status_t status;
    logic    in_fire;
    logic    out_load;
    logic    out_free;
    logic    ready_int;

    logic signed [SAMPLE_WIDTH-1:0] dp_sample;
    logic signed [DB_W-1:0]         dp_gain;

    logic          m_valid_reg;
    logic [OW-1:0] m_data_reg;

    assign s_axis_tready = ready_int;
    assign in_fire       = s_axis_tvalid && ready_int;
    // The output register frees up as soon as its beat is taken.
    assign out_free      = !m_valid_reg || m_axis_tready;

    adrc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd),
        .s_ready  (ready_int),
        .out_load (out_load)
    );

    adrc_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sample_in     (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .bypass_enable (bypass_reg),
        .threshold_db  (threshold_reg),
        .inverse_ratio (inv_ratio_reg),
        .attack_coeff  (attack_reg),
        .release_coeff (release_reg),
        .makeup_db     (makeup_reg),
        .status        (status),
        .sample_out    (dp_sample),
        .gain_db       (dp_gain)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= OW'({dp_gain, dp_sample});
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// File: test/testbench.sv
// Self-checking testbench for the audio dynamic range compressor.
module testbench;
    import adrc_pkg::*;

    localparam int SW = 24;
    localparam int CW = 16;
    localparam int LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    audio_dynamic_range_compressor DUT (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state: a private copy of the registers and the envelope.
    logic        p_bypass;
    longint      p_threshold;
    longint      p_inv_ratio;
    longint      p_attack;
    longint      p_release;
    longint      p_makeup;
    longint      p_envelope;

    typedef struct {
        logic [23:0] sample;
        logic [16:0] gain;
    } result_t;

    result_t     expected_results[$];
    int          errors = 0;
    int          cycles = 0;
    int          stall_left = 0;
    bit          quiet = 0;   // no idling during the last part of the run

    longint log2_tab[17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
        42196, 45903, 49471, 52910, 56228, 59433, 62534, 65536};
    longint exp2_tab[17] = '{65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752,
        92682, 96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072};

    function automatic longint magnitude_to_db(longint mag);
        int     e;
        longint norm, idx, rem, fr, neg;
        if (mag == 0)
            return -46080;
        e = 0;
        for (int i = 0; i < 32; i++)
            if ((mag >> i) & 1)
                e = i;
        norm = (mag << (31 - e)) & 64'hFFFF_FFFF;
        norm = norm & 64'h7FFF_FFFF;
        idx = norm >> 27;
        rem = (norm >> 11) & 16'hFFFF;
        fr = log2_tab[idx] + (((log2_tab[idx + 1] - log2_tab[idx]) * rem) >>> 16);
        neg = longint'(SW - 1 - e) * 65536 - fr;
        if (neg < 0)
            neg = 0;
        return -((neg * 394566 + (64'd1 << 23)) >> 24);
    endfunction

    function automatic longint smooth_envelope(longint env, longint level, longint c);
        longint s;
        s = c * env + ((64'sd1 << CW) - c) * level + (64'sd65536 << CW) + (64'sd1 << (CW - 1));
        return (s >>> CW) - 65536;
    endfunction

    function automatic longint scale_sample(longint x, longint gain);
        longint t, e2, u, n, f, idx, rem, m, mag, p, r, lim;
        int     s;
        t = gain * 10885;
        e2 = (t >= 0) ? ((t + 128) >>> 8) : -((-t + 128) >>> 8);
        u = e2 + (64'sd64 << 16);
        n = (u >>> 16) - 64;
        f = u & 16'hFFFF;
        idx = f >> 12;
        rem = f & 12'hFFF;
        m = exp2_tab[idx] + (((exp2_tab[idx + 1] - exp2_tab[idx]) * rem) >>> 12);
        mag = (x < 0) ? -x : x;
        p = mag * m;
        s = 16 - int'(n);
        if (s < 1)
            s = 1;
        r = (s > 62) ? 0 : ((p + (64'sd1 << (s - 1))) >>> s);
        lim = (x < 0) ? (64'sd1 << (SW - 1)) : ((64'sd1 << (SW - 1)) - 1);
        if (r > lim)
            r = lim;
        return (x < 0) ? -r : r;
    endfunction

    // Works out the result of one sample and advances the envelope.
    function automatic result_t compress_sample(logic [23:0] raw);
        result_t res;
        longint  x, level, gain, inv, over, mk;
        x = longint'($signed(raw));
        if (p_bypass)
        begin
            res.sample = raw;
            res.gain = '0;
            return res;
        end
        level = magnitude_to_db((x < 0) ? -x : x);
        p_envelope = smooth_envelope(p_envelope, level,
                                     (level > p_envelope) ? p_attack : p_release);
        inv = (p_inv_ratio > 65536) ? 65536 : p_inv_ratio;
        gain = 0;
        if (p_envelope > p_threshold)
        begin
            over = p_envelope - p_threshold;
            gain = -((over * (65536 - inv) + 32768) >>> 16);
        end
        mk = (p_makeup > 6144) ? 6144 : p_makeup;
        gain += mk;
        res.sample = 24'(scale_sample(x, gain));
        res.gain = 17'(gain);
        return res;
    endfunction

    // Sometimes idles the input for a short burst, with the valid line low.
    task automatic random_gap();
        if (!quiet && $urandom_range(3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(negedge clk);
        end
    endtask

    // One APB write; the predictor copy follows the same register.
    task automatic write_register(logic [2:0] index, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(index) << 2;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_BYPASS:    p_bypass = value[0];
            REG_THRESHOLD: p_threshold = longint'($signed(value[14:0]));
            REG_INV_RATIO: p_inv_ratio = longint'(value[16:0]);
            REG_ATTACK:    p_attack = longint'(value[CW-1:0]);
            REG_RELEASE:   p_release = longint'(value[CW-1:0]);
            REG_MAKEUP:    p_makeup = longint'(value[12:0]);
            default: ;
        endcase
    endtask

    // Sends one sample beat and queues its expected result. The valid line
    // stays high so that the next beat can follow without a gap.
    task automatic send_sample(logic [23:0] value);
        random_gap();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= value;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_results.push_back(compress_sample(value));
        @(negedge clk);
    endtask

    // Stops sending, waits until every result has arrived, then lets the
    // pipeline settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic configure(logic byp, int thr, int inv, int att, int rel, int mk);
        drain();
        write_register(REG_BYPASS, 32'(byp));
        write_register(REG_THRESHOLD, 32'(thr));
        write_register(REG_INV_RATIO, inv);
        write_register(REG_ATTACK, att);
        write_register(REG_RELEASE, rel);
        write_register(REG_MAKEUP, mk);
    endtask

    function automatic logic [23:0] random_sample();
        case ($urandom_range(5))
            0: return 24'($urandom_range(15));
            1: return -24'($urandom_range(16));
            2: return 24'($urandom) >> $urandom_range(23);
            default: return 24'($urandom);
        endcase
    endfunction

    // Field extremes and zero at the register defaults, then register corner cases.
    task automatic test_directed();
        logic [23:0] corners[10] = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'h000001,
            24'hFFFFFF, 24'h400000, 24'hC00000, 24'h123456, 24'h000000, 24'h555555};
        foreach (corners[i])
            send_sample(corners[i]);
        configure(0, -15360, 3276, 0, 0, 6144);
        foreach (corners[i])
            send_sample(corners[i]);
        // Limiter, an over-range ratio, over-range makeup, a positive threshold, then bypass.
        configure(0, -2560, 0, 65535, 65535, 8191);
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);
        configure(0, 16383, 131071, 30000, 60000, 100);
        send_sample(24'h7FFFFF);
        send_sample(24'h000000);
        configure(1, -3000, 20000, 1000, 2000, 500);
        send_sample(24'h800000);
        send_sample(24'h7FFFFF);
        send_sample(24'h000000);
    endtask

    // Several random register settings, each followed by random audio.
    task automatic test_random();
        for (int phase = 0; phase < 8; phase++)
        begin
            configure(($urandom_range(7) == 0), -int'($urandom_range(15360)),
                      $urandom_range(65536, 3276), $urandom_range(65535),
                      $urandom_range(65535), $urandom_range(6144));
            if (phase == 7)
                quiet = 1;
            for (int i = 0; i < 100; i++)
            begin
                send_sample(random_sample());
                // Hold the sender off once so the output fully drains.
                if (phase == 2 && i == 50)
                    drain();
            end
        end
    endtask

    // Output side: random stall bursts on tready.
    always @(negedge clk)
    begin
        if (quiet)
            m_axis_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(3) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= int'($urandom_range(4));
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Comparison of each output beat with the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        cycles <= cycles + 1;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result beat %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_axis_tdata[23:0] !== want.sample)
                begin
                    $error("sample_out expected %h actual %h", want.sample, m_axis_tdata[23:0]);
                    errors++;
                end
                if (m_axis_tdata[40:24] !== want.gain)
                begin
                    $error("gain_db expected %h actual %h", want.gain, m_axis_tdata[40:24]);
                    errors++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
        if (cycles > LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end

    initial
    begin
        p_bypass = 0;
        p_threshold = 0;
        p_inv_ratio = 65536;
        p_attack = 0;
        p_release = 0;
        p_makeup = 0;
        p_envelope = -36864;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random();
        drain();
        if (errors == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
